/* rtl/core/skbs_pkg.sv */
// shared types and constants for the sorted key binary search unit
package skbs_pkg;

    localparam int unsigned IDX_W = 10;
    localparam int unsigned KEY_W = 32;
    localparam int unsigned CNT_W = 11;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef struct packed {
        logic                    op;
        logic [IDX_W-1:0]        index;
        logic signed [KEY_W-1:0] key;
    } in_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] position;
    } out_t;

    // controller to datapath
    typedef struct packed {
        logic wr;
        logic load;
        logic probe;
        logic step;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic range_done;
    } status_t;

endpackage

/* rtl/core/skbs_ctrl.sv */
// controller state machine for the sorted key binary search unit
module skbs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_op,
    output logic              out_valid,
    input  logic              out_ready,
    input  skbs_pkg::status_t status,
    output skbs_pkg::cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PROBE = 2'd1;
    localparam logic [1:0] ST_CMP   = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       in_fire;
    logic       out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_op == skbs_pkg::OP_SEARCH)
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_PROBE;
                    end
                    else
                    begin
                        cmd.wr = 1'b1;
                    end
                end
            end
            ST_PROBE:
            begin
                if (status.range_done)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.probe  = 1'b1;
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                cmd.step   = 1'b1;
                state_next = ST_PROBE;
            end
            ST_DONE:
            begin
                // hold the finished search until the output register frees up
                if (out_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/core/skbs_dpath.sv */
// key table memory, search bounds and result register
module skbs_dpath #(
    parameter int unsigned TABLE_DEPTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [skbs_pkg::CNT_W-1:0]    cfg_data,
    input  skbs_pkg::in_t                 in_data,
    input  skbs_pkg::cmd_t                cmd,
    output skbs_pkg::status_t             status,
    output skbs_pkg::out_t                out_data
);

    localparam int unsigned AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW   = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned CMPW = (CW > skbs_pkg::CNT_W) ? CW : skbs_pkg::CNT_W;
    localparam int unsigned IW   = (AW > skbs_pkg::IDX_W) ? AW : skbs_pkg::IDX_W;

    logic [31:0]                   mem [TABLE_DEPTH];
    logic [31:0]                   rdata_reg;
    logic [skbs_pkg::CNT_W-1:0]    count_reg;
    logic signed [31:0]            key_reg;
    logic [CW-1:0]                 lo_reg;
    logic [CW-1:0]                 hi_reg;
    logic [CW-1:0]                 mid_reg;
    logic [CW-1:0]                 mid_next;
    logic [CW:0]                   bound_sum;
    logic                          found_reg;
    skbs_pkg::out_t                out_reg;
    logic [CMPW-1:0]               count_ext;
    logic [CW-1:0]                 hi_start;
    logic [CMPW-1:0]               wr_index_ext;
    logic                          wr_in_range;
    logic [IW-1:0]                 wr_addr_ext;
    logic [IW-1:0]                 mid_ext;

    assign count_ext = CMPW'(count_reg);
    assign hi_start  = (count_ext > CMPW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(count_ext);

    assign wr_index_ext = CMPW'(in_data.index);
    assign wr_in_range  = (wr_index_ext < CMPW'(TABLE_DEPTH));
    assign wr_addr_ext  = IW'(in_data.index);

    assign bound_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_next  = bound_sum[CW:1];
    assign mid_ext   = IW'(mid_reg);

    assign status.range_done = (lo_reg >= hi_reg);
    assign out_data          = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg_we)
        begin
            count_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr && wr_in_range)
        begin
            mem[wr_addr_ext[AW-1:0]] <= in_data.key;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.probe)
        begin
            rdata_reg <= mem[mid_next[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg   <= in_data.key;
            lo_reg    <= '0;
            hi_reg    <= hi_start;
            found_reg <= 1'b0;
        end
        else if (cmd.probe)
        begin
            mid_reg <= mid_next;
        end
        else if (cmd.step)
        begin
            if (key_reg < $signed(rdata_reg))
            begin
                hi_reg <= mid_reg;
            end
            else if (key_reg > $signed(rdata_reg))
            begin
                lo_reg <= mid_reg + CW'(1);
            end
            else
            begin
                // match: close the range so the next check ends the search
                found_reg <= 1'b1;
                hi_reg    <= lo_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_reg.found    <= found_reg;
            out_reg.position <= found_reg ? mid_ext[skbs_pkg::IDX_W-1:0] : '0;
        end
    end

endmodule

/* rtl/core/sorted_key_binary_search_unit.sv */
// top level of the sorted key binary search unit
//
//   channel  direction  handshake                  beat
//   in       input      in_valid / in_ready        op, index, key
//   out      output     out_valid / out_ready      found, position
//   cfg      input      cfg_we                     entry_count
//
// a write beat gives no result
// a search makes up to floor(log2(n))+1 probes for n entries in use, each
// a table read and then a compare
// the key table is not cleared at reset; only control state and entry_count are
// a result waits in the output register while the next beat is accepted; a
// search that finishes while that register is still held waits for it
module sorted_key_binary_search_unit #(
    parameter int unsigned TABLE_DEPTH = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  skbs_pkg::in_t              in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output skbs_pkg::out_t             out_data,
    input  logic                       cfg_we,
    input  logic [skbs_pkg::CNT_W-1:0] cfg_data
);

    skbs_pkg::cmd_t    cmd;
    skbs_pkg::status_t status;

    skbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_op     (in_data.op),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    skbs_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_data  (in_data),
        .cmd      (cmd),
        .status   (status),
        .out_data (out_data)
    );

endmodule
